[sv/segment_mmu_translate_defines.svh]
`ifndef SEGMENT_MMU_TRANSLATE_DEFINES_SVH
`define SEGMENT_MMU_TRANSLATE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SMMU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define SMMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/smmu_pkg.sv]
`timescale 1ns / 1ps

package smmu_pkg;

   localparam int ENTRIES     = 32;
   localparam int CELL_IDX_W  = 7;
   localparam int ADDR_W      = 32;
   localparam int OP_W        = 3;
   localparam int SIZE_W      = 2;
   localparam int MAP_WORD_W  = 7;
   localparam int MAP_ENTRY_W = 5;
   localparam int CAUSE_W     = 3;
   localparam int HIT_W       = 5;
   localparam int PERM_W      = 3;

   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
   localparam logic [OP_W-1:0] OP_FETCH  = 3'd2;
   localparam logic [OP_W-1:0] OP_MAP_WR = 3'd3;
   localparam logic [OP_W-1:0] OP_MAP_RD = 3'd4;

   localparam logic [1:0] WORD_PBASE  = 2'd0;
   localparam logic [1:0] WORD_VBASE  = 2'd1;
   localparam logic [1:0] WORD_LENGTH = 2'd2;
   localparam logic [1:0] WORD_PERM   = 2'd3;

   localparam int PERM_READ_BIT  = 0;
   localparam int PERM_WRITE_BIT = 1;
   localparam int PERM_EXEC_BIT  = 2;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE       = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_NOMAP      = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_READ_DENY  = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_WRITE_DENY = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_EXEC_DENY  = 3'd4;

   // One beat moving down the row of segment cells.
   typedef struct packed {
      logic                  valid;
      logic [OP_W-1:0]       op;
      logic [ADDR_W-1:0]     address;
      logic [SIZE_W-1:0]     size;
      logic [MAP_WORD_W-1:0] map_word;
      logic [ADDR_W-1:0]     write_value;
      logic                  found;
      logic [HIT_W-1:0]      hit;
      logic [PERM_W-1:0]     perm;
      logic [ADDR_W-1:0]     phys;
      logic [ADDR_W-1:0]     rdata;
   } stage_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  phys;
      logic [CAUSE_W-1:0] cause;
      logic [HIT_W-1:0]   hit;
      logic [SIZE_W-1:0]  size;
      logic [ADDR_W-1:0]  rdata;
   } result_type;

   function automatic logic is_access(input logic [OP_W-1:0] op);
      return (op == OP_READ) || (op == OP_WRITE) || (op == OP_FETCH);
   endfunction

endpackage

[sv/segment_mmu_translate.sv]
`timescale 1ns / 1ps
// Base-limit segment translator. Request beats enter on req_*, one result
// beat per request leaves on rsp_* in the same order.
// req_tuser carries the operation: read, write, fetch, map word write or
// map word read. Map words are addressed as entry * 4 + word.
// Each segment lives in its own cell; cells form a row and a beat moves one
// cell down the row per cycle while the row is not held. A translation is
// claimed by the first cell whose range covers the address; a map write lands
// when the beat reaches its cell, so every beat sees all map writes issued
// ahead of it. Each beat is registered in every cell, then in the output register.
// Throughput: one beat per cycle while the receiver does not stall, set by the cell row advancing in lockstep.
// Reset clears every segment (zero length, so nothing matches) and empties
// the row and the output register; reset is synchronous.
// When the receiver stalls with a result held, the whole row holds and
// req_tready drops in the same cycle; nothing is dropped or repeated.
`include "segment_mmu_translate_defines.svh"

module segment_mmu_translate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] address, [33:32] access_size, [40:34] map_word,
   // [72:41] write_value, [79:73] zero
   input  logic [79:0] req_tdata,
   // [2:0] operation
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] physical_address, [34:32] fault_cause, [39:35] hit_entry,
   // [41:40] size_out, [73:42] map_read_data, [79:74] zero
   output logic [79:0] rsp_tdata
);

   smmu_pkg::stage_type  chain [0:smmu_pkg::ENTRIES];
   smmu_pkg::result_type result;
   logic                 advance;

   // build the beat entering the first cell
   always_comb begin
      chain[0].valid       = req_tvalid;
      chain[0].op          = req_tuser;
      chain[0].address     = req_tdata[31:0];
      chain[0].size        = req_tdata[33:32];
      chain[0].map_word    = req_tdata[40:34];
      chain[0].write_value = req_tdata[72:41];
      chain[0].found       = 1'b0;
      chain[0].hit         = '0;
      chain[0].perm        = '0;
      chain[0].phys        = '0;
      chain[0].rdata       = '0;
   end

   // one cell per segment, in search order
   for (genvar g = 0; g < smmu_pkg::ENTRIES; g++) begin : g_cell
      smmu_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (smmu_pkg::CELL_IDX_W'(g)),
         .advance    (advance),
         .up_stage   (chain[g]),
         .down_stage (chain[g+1])
      );
   end

   // form the fault cause and hold the result for the receiver
   smmu_resp u_resp (
      .clock      (clock),
      .reset      (reset),
      .last_stage (chain[smmu_pkg::ENTRIES]),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .result     (result)
   );

   assign req_tready = advance;
   assign rsp_tdata  = {6'b0, result.rdata, result.size, result.hit, result.cause, result.phys};

   `SMMU_ASSERT_NEXT(a_row_holds, clock, reset,
      chain[smmu_pkg::ENTRIES].valid && !advance,
      $stable(chain[smmu_pkg::ENTRIES]),
      "row moved while the output was stalled")

   `SMMU_ASSERT_NOW(a_found_only_access, clock, reset,
      chain[smmu_pkg::ENTRIES].valid && chain[smmu_pkg::ENTRIES].found,
      smmu_pkg::is_access(chain[smmu_pkg::ENTRIES].op),
      "segment claimed by a non-access beat")

   `SMMU_ASSERT_NOW(a_fault_no_addr, clock, reset,
      rsp_tvalid && (result.cause != smmu_pkg::CAUSE_NONE),
      (result.phys == '0) && (result.rdata == '0),
      "faulting result carries an address or map data")

endmodule

[sv/smmu_cell.sv]
`timescale 1ns / 1ps

module smmu_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [smmu_pkg::CELL_IDX_W-1:0]     cell_index,
   input  logic                                advance,
   input  smmu_pkg::stage_type                 up_stage,
   output smmu_pkg::stage_type                 down_stage
);

   logic [smmu_pkg::ADDR_W-1:0] pbase_ff, pbase_in;
   logic [smmu_pkg::ADDR_W-1:0] vbase_ff, vbase_in;
   logic [smmu_pkg::ADDR_W-1:0] length_ff, length_in;
   logic [smmu_pkg::ADDR_W-1:0] limit_ff, limit_in;   // vbase + length, wrapped
   logic [smmu_pkg::ADDR_W-1:0] offset_ff, offset_in; // pbase - vbase, wrapped
   logic [smmu_pkg::PERM_W-1:0] perm_ff, perm_in;
   smmu_pkg::stage_type         stage_ff, stage_in;

   logic [smmu_pkg::CELL_IDX_W-1:0] entry;
   logic                            selected;
   logic                            in_range;

   always_comb begin
      entry    = {{(smmu_pkg::CELL_IDX_W - smmu_pkg::MAP_ENTRY_W){1'b0}},
                  up_stage.map_word[smmu_pkg::MAP_WORD_W-1:2]};
      selected = (entry == cell_index);
      in_range = (up_stage.address >= vbase_ff) && (up_stage.address < limit_ff);

      stage_in = up_stage;
      // claim the beat if no earlier segment did
      if (smmu_pkg::is_access(up_stage.op) && !up_stage.found && in_range) begin
         stage_in.found = 1'b1;
         stage_in.hit   = cell_index[smmu_pkg::HIT_W-1:0];
         stage_in.perm  = perm_ff;
         stage_in.phys  = up_stage.address + offset_ff;
      end
      if ((up_stage.op == smmu_pkg::OP_MAP_RD) && selected) begin
         case (up_stage.map_word[1:0])
            smmu_pkg::WORD_PBASE:  stage_in.rdata = pbase_ff;
            smmu_pkg::WORD_VBASE:  stage_in.rdata = vbase_ff;
            smmu_pkg::WORD_LENGTH: stage_in.rdata = length_ff;
            default: stage_in.rdata = {{(smmu_pkg::ADDR_W - smmu_pkg::PERM_W){1'b0}}, perm_ff};
         endcase
      end

      pbase_in  = pbase_ff;
      vbase_in  = vbase_ff;
      length_in = length_ff;
      limit_in  = limit_ff;
      offset_in = offset_ff;
      perm_in   = perm_ff;
      if (up_stage.valid && advance && (up_stage.op == smmu_pkg::OP_MAP_WR) && selected) begin
         case (up_stage.map_word[1:0])
            smmu_pkg::WORD_PBASE: begin
               pbase_in  = up_stage.write_value;
               offset_in = up_stage.write_value - vbase_ff;
            end
            smmu_pkg::WORD_VBASE: begin
               vbase_in  = up_stage.write_value;
               limit_in  = up_stage.write_value + length_ff;
               offset_in = pbase_ff - up_stage.write_value;
            end
            smmu_pkg::WORD_LENGTH: begin
               length_in = up_stage.write_value;
               limit_in  = vbase_ff + up_stage.write_value;
            end
            default: perm_in = up_stage.write_value[smmu_pkg::PERM_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbase_ff       <= '0;
         vbase_ff       <= '0;
         length_ff      <= '0;
         limit_ff       <= '0;
         offset_ff      <= '0;
         perm_ff        <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         pbase_ff  <= pbase_in;
         vbase_ff  <= vbase_in;
         length_ff <= length_in;
         limit_ff  <= limit_in;
         offset_ff <= offset_in;
         perm_ff   <= perm_in;
         if (advance) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign down_stage = stage_ff;

endmodule

[sv/smmu_resp.sv]
`timescale 1ns / 1ps

module smmu_resp (
   input  logic                   clock,
   input  logic                   reset,
   input  smmu_pkg::stage_type    last_stage,
   input  logic                   rsp_tready,
   output logic                   advance,
   output logic                   rsp_valid,
   output smmu_pkg::result_type   result
);

   logic                 rsp_valid_ff;
   smmu_pkg::result_type result_ff, result_in;
   logic [smmu_pkg::CAUSE_W-1:0] cause;
   logic                         access;

   assign advance = !rsp_valid_ff || rsp_tready;

   always_comb begin
      access = smmu_pkg::is_access(last_stage.op);
      cause  = smmu_pkg::CAUSE_NONE;
      if (access && !last_stage.found) begin
         cause = smmu_pkg::CAUSE_NOMAP;
      end else if (access) begin
         case (last_stage.op)
            smmu_pkg::OP_READ:
               if (!last_stage.perm[smmu_pkg::PERM_READ_BIT]) cause = smmu_pkg::CAUSE_READ_DENY;
            smmu_pkg::OP_WRITE:
               if (!last_stage.perm[smmu_pkg::PERM_WRITE_BIT]) cause = smmu_pkg::CAUSE_WRITE_DENY;
            default:
               // fetch: execute first, then read
               if (!last_stage.perm[smmu_pkg::PERM_EXEC_BIT]) cause = smmu_pkg::CAUSE_EXEC_DENY;
               else if (!last_stage.perm[smmu_pkg::PERM_READ_BIT]) cause = smmu_pkg::CAUSE_READ_DENY;
         endcase
      end

      result_in.cause = cause;
      result_in.phys  = (access && (cause == smmu_pkg::CAUSE_NONE)) ? last_stage.phys : '0;
      result_in.hit   = (access && last_stage.found) ? last_stage.hit : '0;
      result_in.size  = access ? last_stage.size : '0;
      result_in.rdata = (last_stage.op == smmu_pkg::OP_MAP_RD) ? last_stage.rdata : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_stage.valid;
         result_ff    <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule
